@@ design/sweig_pkg.sv @@
`timescale 1ns / 1ps

package sweig_pkg;

    // field and datapath widths
    localparam int Q_W      = 32;
    localparam int G_W      = 31;
    localparam int DIV_W    = 49;
    localparam int DEN_W    = 33;
    localparam int RAD_W    = 62;
    localparam int ROOT_W   = 31;
    localparam int ADDR_W   = 3;

    localparam int DIV_STAGES  = DIV_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int ROOT_DLY    = DIV_STAGES - SQRT_STAGES - 1;
    // input reg, prep, divider, three glue stages, divider, output reg
    localparam int PIPE_DEPTH  = 2 * DIV_STAGES + 6;

    localparam logic [G_W-1:0]    GRAVITY_RESET = G_W'(642908);
    localparam logic [ADDR_W-1:0] ADDR_GRAVITY  = ADDR_W'(0);
    localparam logic [DIV_W-1:0]  INV_NUM       = DIV_W'(64'h1_0000_0000);

    // per-item flags riding along the first divider
    typedef struct packed {
        logic       fault;
        logic       hyp;
        logic [2:0] u_neg;
    } sb1_t;

    // per-item payload riding along the second divider
    typedef struct packed {
        logic [5:0][Q_W-1:0] lam;
        logic                hyp;
        logic                fault;
        logic                neg00;
        logic                neg10;
        logic                cm_nz;
    } sb2_t;

    // signed result from sign and magnitude, clamped to 32 bits
    function automatic logic [Q_W-1:0] sat_mag(input logic neg, input logic [DIV_W-1:0] mag);
        logic [Q_W-1:0] r;
        if (!neg) begin
            if (mag[DIV_W-1:Q_W-1] != '0) begin
                r = {1'b0, {(Q_W-1){1'b1}}};
            end else begin
                r = mag[Q_W-1:0];
            end
        end else begin
            if ((mag[DIV_W-1:Q_W] != '0) || (mag[Q_W-1] && (mag[Q_W-2:0] != '0))) begin
                r = {1'b1, {(Q_W-1){1'b0}}};
            end else begin
                r = Q_W'(0) - mag[Q_W-1:0];
            end
        end
        return r;
    endfunction

    // clamp a 34-bit signed sum to 32 bits
    function automatic logic [Q_W-1:0] sat34(input logic [Q_W+1:0] v);
        logic [Q_W-1:0] r;
        if ((v[Q_W+1:Q_W-1] == 3'b000) || (v[Q_W+1:Q_W-1] == 3'b111)) begin
            r = v[Q_W-1:0];
        end else if (v[Q_W+1]) begin
            r = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(Q_W-1){1'b1}}};
        end
        return r;
    endfunction

    // two's complement magnitude of a 32-bit signed value
    function automatic logic [Q_W-1:0] abs32(input logic [Q_W-1:0] v);
        return v[Q_W-1] ? (Q_W'(0) - v) : v;
    endfunction

endpackage

@@ design/sweig_div.sv @@
`timescale 1ns / 1ps

module sweig_div (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [sweig_pkg::DIV_W-1:0] num_in,
    input  logic [sweig_pkg::DEN_W-1:0] den_in,
    output logic [sweig_pkg::DIV_W-1:0] quo_out
);
    import sweig_pkg::*;

    // restoring division, one quotient bit per stage
    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [DIV_W-1:0] num_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DEN_W-1:0] rem_prev;
        logic [DIV_W-1:0] num_prev;
        logic [DEN_W-1:0] den_prev;
        logic [DEN_W:0]   trial;
        logic             ge;
        logic [DEN_W:0]   diff;

        if (k == 0) begin : g_first
            assign rem_prev = '0;
            assign num_prev = num_in;
            assign den_prev = den_in;
        end else begin : g_rest
            assign rem_prev = rem_reg[k-1];
            assign num_prev = num_reg[k-1];
            assign den_prev = den_reg[k-1];
        end

        assign trial = {rem_prev, num_prev[DIV_W-1]};
        assign ge    = trial >= {1'b0, den_prev};
        assign diff  = trial - {1'b0, den_prev};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                num_reg[k] <= {num_prev[DIV_W-2:0], ge};
                den_reg[k] <= den_prev;
            end
        end
    end

    assign quo_out = num_reg[DIV_STAGES-1];

endmodule

@@ design/sweig_sqrt.sv @@
`timescale 1ns / 1ps

module sweig_sqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [sweig_pkg::RAD_W-1:0]  rad_in,
    output logic [sweig_pkg::ROOT_W-1:0] root_out
);
    import sweig_pkg::*;

    // digit-by-digit floor square root, one root bit per stage
    logic [RAD_W-1:0]  rad_reg  [SQRT_STAGES];
    logic [ROOT_W+1:0] rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_prev;
        logic [ROOT_W+1:0] rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [ROOT_W+3:0] work;
        logic [ROOT_W+3:0] trial;
        logic              ge;
        logic [ROOT_W+3:0] diff;

        if (k == 0) begin : g_first
            assign rad_prev  = rad_in;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end else begin : g_rest
            assign rad_prev  = rad_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
        end

        assign work  = {rem_prev, rad_prev[RAD_W-1:RAD_W-2]};
        assign trial = {2'b00, root_prev, 2'b01};
        assign ge    = work >= trial;
        assign diff  = work - trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
                rem_reg[k]  <= ge ? diff[ROOT_W+1:0] : work[ROOT_W+1:0];
                root_reg[k] <= {root_prev[ROOT_W-2:0], ge};
            end
        end
    end

    assign root_out = root_reg[SQRT_STAGES-1];

endmodule

@@ design/shallow_water_interface_eigensystem_top.sv @@
`timescale 1ns / 1ps

// 1d shallow-water eigensystem at a cell interface. each input beat carries depth and
// momentum (signed q16.16) of a left and a right cell; each output beat carries u-c and
// u+c for the left cell, the right cell and the averaged interface, a hyperbolic flag,
// the four interface left-eigenvector entries and a depth fault flag. velocity is
// momentum over depth, celerity is floor(sqrt(g*h)) and zero for negative depth. a zero
// left, right or interface depth sets depth_fault and zeroes everything else; a zero
// interface celerity zeroes the eigenvector entries; all results saturate to 32 bits.
// the block takes one beat per clock while the output side does not stall. the pipeline
// is built around two 49-stage pipelined dividers in series: velocity first, then the
// eigenvector quotients, whose divisor is the interface celerity; the three square
// roots (31 stages) run beside the first divider. a stall on the output holds the
// whole pipeline. gravity is written through the apb port at byte address 0 (unsigned
// q16.16, reset about 9.81).
module shallow_water_interface_eigensystem_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // apb configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sweig_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    // input beats
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [31:0]              s_h_left,
    input  logic signed [31:0]              s_hu_left,
    input  logic signed [31:0]              s_h_right,
    input  logic signed [31:0]              s_hu_right,
    // result beats
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [31:0]              m_lambda_left_minus,
    output logic signed [31:0]              m_lambda_left_plus,
    output logic signed [31:0]              m_lambda_right_minus,
    output logic signed [31:0]              m_lambda_right_plus,
    output logic signed [31:0]              m_lambda_mid_minus,
    output logic signed [31:0]              m_lambda_mid_plus,
    output logic                            m_hyperbolic,
    output logic signed [31:0]              m_left_vec_00,
    output logic signed [31:0]              m_left_vec_01,
    output logic signed [31:0]              m_left_vec_10,
    output logic signed [31:0]              m_left_vec_11,
    output logic                            m_depth_fault
);
    import sweig_pkg::*;

    // ---------------- configuration ----------------
    logic [G_W-1:0] gravity_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GRAVITY) ? {1'b0, gravity_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gravity_reg <= GRAVITY_RESET;
        end else if (psel && penable && pwrite && pready && (paddr == ADDR_GRAVITY)) begin
            gravity_reg <= pwdata[G_W-1:0];
        end
    end

    // ---------------- flow control ----------------
    // one valid bit per stage; the whole pipe moves unless the output beat is stuck
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  en;

    assign en      = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    // ---------------- stage 1: input register ----------------
    logic [Q_W-1:0] hl1_reg, hul1_reg, hr1_reg, hur1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hl1_reg  <= s_h_left;
            hul1_reg <= s_hu_left;
            hr1_reg  <= s_h_right;
            hur1_reg <= s_hu_right;
        end
    end

    // ---------------- stage 2: interface average and flags ----------------
    // index 0 left, 1 right, 2 interface
    logic [Q_W:0]          hsum, husum, hsum_rnd, husum_rnd;
    logic [2:0][Q_W-1:0]   h_next, hu_next;
    logic [2:0][Q_W-1:0]   h2_reg, hu2_reg;
    logic                  fault2_reg, hyp2_reg;

    always_comb begin
        hsum      = {hl1_reg[Q_W-1], hl1_reg} + {hr1_reg[Q_W-1], hr1_reg};
        husum     = {hul1_reg[Q_W-1], hul1_reg} + {hur1_reg[Q_W-1], hur1_reg};
        // adding the sign bit before the shift truncates toward zero
        hsum_rnd  = hsum + {{Q_W{1'b0}}, hsum[Q_W]};
        husum_rnd = husum + {{Q_W{1'b0}}, husum[Q_W]};
        h_next    = {hsum_rnd[Q_W:1], hr1_reg, hl1_reg};
        hu_next   = {husum_rnd[Q_W:1], hur1_reg, hul1_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h2_reg     <= h_next;
            hu2_reg    <= hu_next;
            fault2_reg <= (h_next[0] == '0) || (h_next[1] == '0) || (h_next[2] == '0);
            hyp2_reg   <= !h_next[0][Q_W-1] && !h_next[1][Q_W-1] && !h_next[2][Q_W-1];
        end
    end

    // ---------------- velocity dividers (49 stages) ----------------
    logic [2:0][DIV_W-1:0] quo_u;
    logic [2:0]            u_neg;

    for (genvar i = 0; i < 3; i++) begin : g_udiv
        assign u_neg[i] = hu2_reg[i][Q_W-1] ^ h2_reg[i][Q_W-1];
        sweig_div u_div (
            .aclk    (aclk),
            .en      (en),
            .num_in  ({1'b0, abs32(hu2_reg[i]), 16'd0}),
            .den_in  ({1'b0, abs32(h2_reg[i])}),
            .quo_out (quo_u[i])
        );
    end

    sb1_t sb1_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            sb1_reg[0] <= '{fault: fault2_reg, hyp: hyp2_reg, u_neg: u_neg};
            for (int k = 1; k < DIV_STAGES; k++) begin
                sb1_reg[k] <= sb1_reg[k-1];
            end
        end
    end

    // ---------------- stage 3: g*h, then celerity roots ----------------
    // negative depth feeds zero so its celerity comes out zero
    logic [2:0][RAD_W-1:0]  prod3_reg;
    logic [2:0][ROOT_W-1:0] root;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod3_reg[i] <= h2_reg[i][Q_W-1] ? '0
                              : RAD_W'(gravity_reg) * RAD_W'(h2_reg[i][Q_W-2:0]);
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_root
        sweig_sqrt u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .rad_in   (prod3_reg[i]),
            .root_out (root[i])
        );
    end

    // roots finish early; hold them back to meet the velocity quotients
    logic [2:0][ROOT_W-1:0] root_dly_reg [ROOT_DLY];

    always_ff @(posedge aclk) begin
        if (en) begin
            root_dly_reg[0] <= root;
            for (int k = 1; k < ROOT_DLY; k++) begin
                root_dly_reg[k] <= root_dly_reg[k-1];
            end
        end
    end

    // ---------------- stage 52: signed, saturated velocity ----------------
    logic [2:0][Q_W-1:0]    u52_reg;
    logic [2:0][ROOT_W-1:0] c52_reg;
    logic                   fault52_reg, hyp52_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                u52_reg[i] <= sat_mag(sb1_reg[DIV_STAGES-1].u_neg[i], quo_u[i]);
            end
            c52_reg     <= root_dly_reg[ROOT_DLY-1];
            fault52_reg <= sb1_reg[DIV_STAGES-1].fault;
            hyp52_reg   <= sb1_reg[DIV_STAGES-1].hyp;
        end
    end

    // ---------------- stage 53: eigenvalues and interface sums ----------------
    logic [5:0][Q_W-1:0]  lam53_reg;
    logic [Q_W:0]         a00_53_reg, a10_53_reg;
    logic [ROOT_W-1:0]    cm53_reg;
    logic                 fault53_reg, hyp53_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                lam53_reg[2*i]   <= fault52_reg ? '0
                    : sat34({{2{u52_reg[i][Q_W-1]}}, u52_reg[i]} - {3'b000, c52_reg[i]});
                lam53_reg[2*i+1] <= fault52_reg ? '0
                    : sat34({{2{u52_reg[i][Q_W-1]}}, u52_reg[i]} + {3'b000, c52_reg[i]});
            end
            a00_53_reg  <= {u52_reg[2][Q_W-1], u52_reg[2]} + {2'b00, c52_reg[2]};
            a10_53_reg  <= {u52_reg[2][Q_W-1], u52_reg[2]} - {2'b00, c52_reg[2]};
            cm53_reg    <= c52_reg[2];
            fault53_reg <= fault52_reg;
            hyp53_reg   <= hyp52_reg && !fault52_reg;
        end
    end

    // ---------------- stage 54: divider operands for the eigenvectors ----------------
    logic [DIV_W-1:0] num00_54_reg, num10_54_reg;
    logic [DEN_W-1:0] den54_reg;
    sb2_t             sb2_54_reg;
    logic [Q_W:0]     a00_mag, a10_mag;

    assign a00_mag = a00_53_reg[Q_W] ? ((Q_W+1)'(0) - a00_53_reg) : a00_53_reg;
    assign a10_mag = a10_53_reg[Q_W] ? ((Q_W+1)'(0) - a10_53_reg) : a10_53_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            num00_54_reg     <= {a00_mag, 16'd0};
            num10_54_reg     <= {a10_mag, 16'd0};
            den54_reg        <= {1'b0, cm53_reg, 1'b0};
            sb2_54_reg.lam   <= lam53_reg;
            sb2_54_reg.hyp   <= hyp53_reg;
            sb2_54_reg.fault <= fault53_reg;
            sb2_54_reg.neg00 <= a00_53_reg[Q_W];
            // left_vec_10 is the negated quotient
            sb2_54_reg.neg10 <= !a10_53_reg[Q_W];
            sb2_54_reg.cm_nz <= (cm53_reg != '0);
        end
    end

    // ---------------- eigenvector dividers (49 stages) ----------------
    // 0: (u+c)/(2c), 1: (u-c)/(2c), 2: 1/(2c)
    logic [2:0][DIV_W-1:0] vnum;
    logic [2:0][DIV_W-1:0] quo_v;

    assign vnum = {INV_NUM, num10_54_reg, num00_54_reg};

    for (genvar i = 0; i < 3; i++) begin : g_vdiv
        sweig_div u_div (
            .aclk    (aclk),
            .en      (en),
            .num_in  (vnum[i]),
            .den_in  (den54_reg),
            .quo_out (quo_v[i])
        );
    end

    sb2_t sb2_reg [DIV_STAGES];

    always_ff @(posedge aclk) begin
        if (en) begin
            sb2_reg[0] <= sb2_54_reg;
            for (int k = 1; k < DIV_STAGES; k++) begin
                sb2_reg[k] <= sb2_reg[k-1];
            end
        end
    end

    // ---------------- output register ----------------
    sb2_t           sbo;
    logic           vec_ok;
    logic [Q_W-1:0] lam_o_reg [6];
    logic [Q_W-1:0] v00_reg, v01_reg, v10_reg, v11_reg;
    logic           hyp_o_reg, fault_o_reg;

    assign sbo    = sb2_reg[DIV_STAGES-1];
    assign vec_ok = sbo.cm_nz && !sbo.fault;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                lam_o_reg[i] <= sbo.lam[i];
            end
            v00_reg     <= vec_ok ? sat_mag(sbo.neg00, quo_v[0]) : '0;
            v10_reg     <= vec_ok ? sat_mag(sbo.neg10, quo_v[1]) : '0;
            v11_reg     <= vec_ok ? sat_mag(1'b0, quo_v[2]) : '0;
            v01_reg     <= vec_ok ? sat_mag(1'b1, quo_v[2]) : '0;
            hyp_o_reg   <= sbo.hyp;
            fault_o_reg <= sbo.fault;
        end
    end

    assign m_lambda_left_minus  = lam_o_reg[0];
    assign m_lambda_left_plus   = lam_o_reg[1];
    assign m_lambda_right_minus = lam_o_reg[2];
    assign m_lambda_right_plus  = lam_o_reg[3];
    assign m_lambda_mid_minus   = lam_o_reg[4];
    assign m_lambda_mid_plus    = lam_o_reg[5];
    assign m_hyperbolic         = hyp_o_reg;
    assign m_left_vec_00        = v00_reg;
    assign m_left_vec_01        = v01_reg;
    assign m_left_vec_10        = v10_reg;
    assign m_left_vec_11        = v11_reg;
    assign m_depth_fault        = fault_o_reg;

    // ---------------- checks ----------------
    // a faulted beat carries nothing but the fault flag
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_depth_fault |-> !m_hyperbolic && (m_left_vec_11 == 32'sd0)
            && (m_lambda_mid_plus == 32'sd0) && (m_lambda_left_minus == 32'sd0))
        else $error("faulted beat with nonzero payload");

    // the two reciprocal entries are negatives of each other, up to saturation
    a_inv_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_left_vec_01 == -m_left_vec_11)
            || ((m_left_vec_11 == 32'sh7fffffff) && (m_left_vec_01 == 32'sh80000000)))
        else $error("left_vec_01 does not mirror left_vec_11");

    // celerity is never negative, so the plus speed never falls below the minus speed
    a_speed_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lambda_left_plus >= m_lambda_left_minus)
            && (m_lambda_right_plus >= m_lambda_right_minus)
            && (m_lambda_mid_plus >= m_lambda_mid_minus))
        else $error("eigenvalue pair out of order");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sweig_pkg::*;

    localparam int LATENCY   = 104;
    localparam int MAX_CYC   = 600000;
    localparam int N_RANDOM  = 1630;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        logic signed [31:0] h_l;
        logic signed [31:0] hu_l;
        logic signed [31:0] h_r;
        logic signed [31:0] hu_r;
    } cells_t;

    typedef struct packed {
        logic [31:0] llm, llp, lrm, lrp, lmm, lmp;
        logic        hyp;
        logic [31:0] v00, v01, v10, v11;
        logic        fault;
    } eig_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_h_left = '0, s_hu_left = '0, s_h_right = '0, s_hu_right = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_lambda_left_minus, m_lambda_left_plus;
    logic signed [31:0] m_lambda_right_minus, m_lambda_right_plus;
    logic signed [31:0] m_lambda_mid_minus, m_lambda_mid_plus;
    logic m_hyperbolic, m_depth_fault;
    logic signed [31:0] m_left_vec_00, m_left_vec_01, m_left_vec_10, m_left_vec_11;

    shallow_water_interface_eigensystem_top uut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [30:0] g_reg = GRAVITY_RESET;
    cells_t      pending_cells[$];
    eig_t        expected_eig[$];
    int          mismatches = 0;
    int          cycle = 0;
    bit          feeding_done = 0;
    bit          hold_sender = 0;
    bit          long_stall = 0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint floor_root(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // velocity and celerity of one point, depth nonzero
    function automatic void speeds(longint h, longint hu, output longint u, output longint c,
                                   inout bit hyp);
        u = clamp32((hu * 65536) / h);
        if (h >= 0) begin
            c = floor_root(64'(g_reg) * 64'(h));
        end else begin
            c = 0;
            hyp = 0;
        end
    endfunction

    function automatic eig_t predict_eig(cells_t x);
        eig_t e;
        longint hl, hul, hr, hur, hm, hum, ul, cl, ur, cr, um, cm, d, inv;
        bit hyp;
        e = '0;
        hyp = 1;
        hl = x.h_l; hul = x.hu_l; hr = x.h_r; hur = x.hu_r;
        hm = (hl + hr) / 2;
        hum = (hul + hur) / 2;
        if (hl == 0 || hr == 0 || hm == 0) begin
            e.fault = 1'b1;
            return e;
        end
        speeds(hl, hul, ul, cl, hyp);
        speeds(hr, hur, ur, cr, hyp);
        speeds(hm, hum, um, cm, hyp);
        e.llm = 32'(clamp32(ul - cl));
        e.llp = 32'(clamp32(ul + cl));
        e.lrm = 32'(clamp32(ur - cr));
        e.lrp = 32'(clamp32(ur + cr));
        e.lmm = 32'(clamp32(um - cm));
        e.lmp = 32'(clamp32(um + cm));
        e.hyp = hyp;
        if (cm != 0) begin
            d = 2 * cm;
            inv = (64'sd1 <<< 32) / d;
            e.v00 = 32'(clamp32(((um + cm) * 65536) / d));
            e.v01 = 32'(clamp32(-inv));
            e.v10 = 32'(clamp32(-(((um - cm) * 65536) / d)));
            e.v11 = 32'(clamp32(inv));
        end
        return e;
    endfunction

    // driver: bursts of beats with random gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_eig.push_back(predict_eig({s_h_left, s_hu_left, s_h_right, s_hu_right}));
            end
            if (!s_valid || s_ready) begin
                if (pending_cells.size() > 0 && !hold_sender && gap_left == 0) begin
                    cells_t c;
                    c = pending_cells.pop_front();
                    s_valid <= 1'b1;
                    {s_h_left, s_hu_left, s_h_right, s_hu_right} <= c;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                    end else begin
                        burst_left = burst_left - 1;
                        if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ?
                                                        0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left = gap_left - 1;
                end
            end
        end
    end

    // receiver stall pattern plus one long hold-off counted here
    int stall_phase = 0;
    int long_count = 0;
    always @(posedge aclk) begin
        stall_phase = (stall_phase + 1) % 23;
        if (long_stall) begin
            m_ready <= 1'b0;
            long_count = long_count + 1;
            if (long_count >= LONG_HOLD) begin
                long_count = 0;
                long_stall = 0;
            end
        end
        else if (stall_phase < 8) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (aresetn && m_valid && m_ready) begin
            eig_t got, want;
            got = {m_lambda_left_minus, m_lambda_left_plus, m_lambda_right_minus,
                   m_lambda_right_plus, m_lambda_mid_minus, m_lambda_mid_plus, m_hyperbolic,
                   m_left_vec_00, m_left_vec_01, m_left_vec_10, m_left_vec_11, m_depth_fault};
            if (expected_eig.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
                want = expected_eig.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp lam %h %h %h %h %h %h hyp %b vec %h %h %h %h flt %b",
                                 want.llm, want.llp, want.lrm, want.lrp, want.lmm, want.lmp,
                                 want.hyp, want.v00, want.v01, want.v10, want.v11, want.fault);
                        $display("         got lam %h %h %h %h %h %h hyp %b vec %h %h %h %h flt %b",
                                 got.llm, got.llp, got.lrm, got.lrp, got.lmm, got.lmp,
                                 got.hyp, got.v00, got.v01, got.v10, got.v11, got.fault);
                    end
                end
            end
        end
        if (cycle >= MAX_CYC) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic apb_write_gravity(logic [30:0] g);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_GRAVITY; pwdata <= {1'b0, g};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        g_reg = g;
    endtask

    // checked at the falling edge, when every update of the rising edge has settled
    task automatic drain();
        @(negedge aclk);
        while (pending_cells.size() > 0 || s_valid || expected_eig.size() > 0)
            @(negedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_depth();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return -$urandom_range(1, 1 << 20);
            2: return $urandom_range(1, 8);
            3: return 32'h7fff_ffff - $urandom_range(0, 3);
            default: return $urandom_range(1, 1 << 24);
        endcase
    endfunction

    function automatic logic [31:0] rand_mom();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            default: return 32'($signed($urandom_range(0, 1 << 25)) - (1 << 24));
        endcase
    endfunction

    task automatic push_random(int n);
        cells_t c;
        repeat (n) begin
            c.h_l = rand_depth();
            c.hu_l = rand_mom();
            c.h_r = ($urandom_range(0, 9) == 0) ? -c.h_l : rand_depth();
            c.hu_r = rand_mom();
            if ($urandom_range(0, 30) == 0) c.h_l = 0;
            pending_cells.push_back(c);
        end
    endtask

    localparam logic [31:0] MAXP = 32'h7fff_ffff;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: extremes, zero depths, negative depths, tiny depths
        pending_cells.push_back({ONE, ONE, ONE, -ONE});
        pending_cells.push_back({32'd0, ONE, ONE, ONE});
        pending_cells.push_back({ONE, ONE, 32'd0, ONE});
        pending_cells.push_back({ONE, ONE, -ONE, ONE});
        pending_cells.push_back({-ONE, ONE, -ONE, ONE});
        pending_cells.push_back({MAXP, MAXP, MAXP, MAXP});
        pending_cells.push_back({MINN, MINN, MINN, MINN});
        pending_cells.push_back({32'd1, MAXP, 32'd1, MINN});
        pending_cells.push_back({32'd1, 32'd0, 32'd2, 32'd0});
        pending_cells.push_back({32'd1, ONE, 32'hffff_ffff, ONE});
        pending_cells.push_back({MAXP, MINN, MINN, MAXP});
        pending_cells.push_back({32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
        pending_cells.push_back({32'd5, MINN, 32'd7, MAXP});
        pending_cells.push_back({ONE * 4, ONE * 8, ONE * 2, -ONE * 3});
        drain();
        // extremes of gravity
        apb_write_gravity(31'd0);
        pending_cells.push_back({ONE, ONE, ONE, ONE});
        pending_cells.push_back({MAXP, MINN, 32'd3, MAXP});
        push_random(60);
        drain();
        apb_write_gravity(31'h7fff_ffff);
        pending_cells.push_back({MAXP, 32'd0, MAXP, 32'd0});
        pending_cells.push_back({32'd1, 32'd1, 32'd1, 32'd1});
        push_random(150);
        drain();
        apb_write_gravity(31'd1);
        push_random(150);
        drain();
        // long receiver hold-off while the sender keeps offering
        apb_write_gravity(GRAVITY_RESET);
        push_random(400);
        long_stall = 1;
        wait (!long_stall);
        // sender pauses until everything has come back
        wait (pending_cells.size() == 0);
        hold_sender = 1;
        @(negedge aclk);
        while (expected_eig.size() > 0 || s_valid) @(negedge aclk);
        hold_sender = 0;
        apb_write_gravity(31'($urandom()));
        push_random(N_RANDOM - 760);
        drain();
        if (mismatches == 0 && expected_eig.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
